>>> src/lcks_pkg.sv
// Shared types, constants and helpers of the lane-centre steering block.
package lcks_pkg;

  typedef logic signed [47:0] s48_t;
  typedef logic signed [51:0] s52_t;

  localparam s48_t S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam s48_t S48_MIN = 48'sh8000_0000_0000;
  localparam s52_t L52_MAX = 52'sh0_7FFF_FFFF_FFFF;
  localparam s52_t L52_MIN = 52'shF_8000_0000_0000;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GAIN_P = 3'd1;
  localparam logic [2:0] CFG_GAIN_I = 3'd2;
  localparam logic [2:0] CFG_GAIN_D = 3'd3;
  localparam logic [2:0] CFG_DT     = 3'd4;
  localparam logic [2:0] CFG_QNOISE = 3'd5;
  localparam logic [2:0] CFG_RNOISE = 3'd6;

  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [31:0] RST_GAIN_P = 32'd83886;
  localparam logic [31:0] RST_GAIN_I = 32'd0;
  localparam logic [31:0] RST_GAIN_D = 32'd0;
  localparam logic [30:0] RST_DT     = 31'd1677722;
  localparam logic [30:0] RST_QNOISE = 31'd1678;
  localparam logic [30:0] RST_RNOISE = 31'd1677722;

  // Steering limits for the speed bands, Q8.24 radians.
  localparam logic [32:0] LIM_DEG5    = 33'd1464088;
  localparam logic [32:0] LIM_DEG8    = 33'd2342541;
  localparam logic [32:0] LIM_DEG11P5 = 33'd3367403;
  localparam logic [32:0] LIM_DEG15   = 33'd4392264;

  localparam logic [2:0] SPD_1P5 = 3'd0;
  localparam logic [2:0] SPD_1P2 = 3'd1;
  localparam logic [2:0] SPD_1P0 = 3'd2;
  localparam logic [2:0] SPD_0P8 = 3'd3;
  localparam logic [2:0] SPD_0P7 = 3'd4;

  localparam logic [5:0] SH_DT = 6'd24;
  localparam logic [5:0] SH_KG = 6'd30;

  // Division by eleven and by three as a product with a rounded-up reciprocal.
  // The eleven case is exact for magnitudes below 2^21, the three case below
  // 2^35; beyond that the steering result saturates anyway.
  localparam logic [5:0] SH_C11 = 6'd23;
  localparam logic [5:0] SH_C3  = 6'd35;
  localparam s48_t       RCP_11 = 48'sd762601;
  localparam s48_t       RCP_3  = 48'sd11453246123;

  // Micro-operations, issued in this order for every request.
  typedef enum logic [4:0] {
    OP_CENTER, OP_XP, OP_A, OP_T00, OP_P00, OP_PREP, OP_K0, OP_K1,
    OP_POS, OP_VEL, OP_UP00, OP_UP01, OP_UP11, OP_PID, OP_UP, OP_UI,
    OP_UD, OP_STEER, OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOCAL, KIND_MUL, KIND_DIV
  } kind_e;

  typedef struct packed {
    logic load;
    logic start;
    logic wb;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_full;
  } sts_t;

  function automatic kind_e op_kind(input op_e op);
    kind_e k;
    case (op)
      OP_K0, OP_K1:            k = KIND_DIV;
      OP_PREP, OP_PID, OP_OUT: k = KIND_LOCAL;
      default:                 k = KIND_MUL;
    endcase
    return k;
  endfunction

  function automatic s52_t ext52(input s48_t v);
    return {{4{v[47]}}, v};
  endfunction

  function automatic s48_t sat48(input s52_t v);
    s48_t r;
    if (v > L52_MAX) r = S48_MAX;
    else if (v < L52_MIN) r = S48_MIN;
    else r = v[47:0];
    return r;
  endfunction

endpackage

>>> src/lane_center_kalman_pid_steer.sv
// Lane-centre steering block: Kalman-smoothed lane centre driving a PID, top level.
//
// Usage: one request per camera frame arrives on the s_axis channel with the
// number of lane lines and their bottom-row x positions. One result per
// request leaves on the m_axis channel: steering angle, speed band, raw and
// filtered lane centre. Registers are written on the cfg channel, which is
// always ready; the user must write them only while no request is in flight,
// which the block itself does not enforce. One request is worked through to
// its result before the next is accepted. The restoring divider for the two
// Kalman gains (78 quotient bits each) takes most of a request's time; the
// fourteen products of the shared multiplier, which also divide the centre by
// eleven and the steering sum by three through reciprocals, take most of the rest.
// s_axis_tready is high only while the block waits for a request.
// Reset clears the filter to position zero, unit covariance and zero PID
// history, and loads the register defaults.
// A finished result waits in an output register; if the receiver stalls, the
// next request is still accepted and computed, and only its final write waits
// until the register is free.
module lane_center_kalman_pid_steer #(
  parameter int STATE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // lines_found[1:0], first_x[17:2], second_x[33:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // steer_cmd[31:0], speed_code[34:32],
                                     // raw_center[50:35], filtered_center[66:51]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import lcks_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] steer;
  logic [2:0]  speed;
  logic [15:0] raw, filt;

  assign cfg_ready_o = 1'b1;

  lcks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcks_dp #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .lines_found_i     (s_axis_tdata[1:0]),
    .first_x_i         (s_axis_tdata[17:2]),
    .second_x_i        (s_axis_tdata[33:18]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .steer_cmd_o       (steer),
    .speed_code_o      (speed),
    .raw_center_o      (raw),
    .filtered_center_o (filt)
  );

  assign m_axis_tdata = {5'b0, filt, raw, speed, steer};

endmodule

>>> src/lcks_mul.sv
// Sequential 48 x 48 signed multiplier with truncating shift and 48-bit saturation.
module lcks_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  lcks_pkg::s48_t       a_i,
  input  lcks_pkg::s48_t       b_i,
  input  logic [5:0]           sh_i,
  output logic                 done_o,
  output lcks_pkg::s48_t       res_o
);
  import lcks_pkg::*;

  logic        busy_q, busy_d, fin_q, fin_d, done_q, done_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        neg_q;
  logic [47:0] ua_q, ub_q;
  logic [5:0]  sh_q;
  logic [95:0] acc_q, acc_d;
  s48_t        res_q, res_d;
  logic [15:0] digit;
  logic [63:0] pp;
  logic [95:0] shifted;
  logic [47:0] lim, mres;

  always_comb begin
    case (cnt_q)
      2'd0:    digit = ub_q[15:0];
      2'd1:    digit = ub_q[31:16];
      default: digit = ub_q[47:32];
    endcase
    pp      = ua_q * digit;
    shifted = acc_q >> sh_q;
    lim     = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    mres    = ((|shifted[95:48]) || (shifted[47:0] > lim)) ? lim : shifted[47:0];

    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + ({32'b0, pp} << {cnt_q, 4'b0});
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      res_d  = neg_q ? -$signed(mres) : $signed(mres);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    res_q <= res_d;
    if (start_i) begin
      neg_q <= a_i[47] ^ b_i[47];
      ua_q  <= a_i[47] ? 48'(-a_i) : 48'(a_i);
      ub_q  <= b_i[47] ? 48'(-b_i) : 48'(b_i);
      sh_q  <= sh_i;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/lcks_div.sv
// Restoring divider, one quotient bit a cycle, plain or Q.30 fraction mode.
module lcks_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                frac_i,
  input  logic signed [49:0]  num_i,
  input  logic [47:0]         den_i,
  output logic                done_o,
  output logic signed [50:0]  quo_o
);
  import lcks_pkg::*;

  localparam logic [6:0] FRAC_ITER = 7'd78;
  localparam logic [6:0] INT_ITER  = 7'd50;

  logic        busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, frac_q, sat_q, sat_d;
  logic [47:0] den_q;
  logic [79:0] nreg_q, nreg_d;
  logic [48:0] rem_q, rem_d, remn;
  logic [49:0] q_q, q_d, qn, mq, m;
  logic        ge;

  assign m = num_i[49] ? 50'(-num_i) : 50'(num_i);

  always_comb begin
    remn   = {rem_q[47:0], nreg_q[79]};
    ge     = remn >= {1'b0, den_q};
    qn     = {q_q[48:0], ge};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nreg_d = nreg_q;
    rem_d  = rem_q;
    q_d    = q_q;
    sat_d  = sat_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = frac_i ? FRAC_ITER : INT_ITER;
      nreg_d = frac_i ? {m[47:0], 32'b0} : {m, 30'b0};
      rem_d  = '0;
      q_d    = '0;
      sat_d  = 1'b0;
    end else if (busy_q) begin
      nreg_d = {nreg_q[78:0], 1'b0};
      rem_d  = ge ? remn - {1'b0, den_q} : remn;
      q_d    = qn;
      // The fraction result saturates once it no longer fits 47 magnitude bits.
      sat_d  = sat_q | (frac_q & qn[47]);
      cnt_d  = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nreg_q <= nreg_d;
    rem_q  <= rem_d;
    q_q    <= q_d;
    sat_q  <= sat_d;
    if (start_i) begin
      neg_q  <= num_i[49];
      frac_q <= frac_i;
      den_q  <= den_i;
    end
  end

  assign mq     = (frac_q && sat_q) ? {3'b0, 47'h7FFF_FFFF_FFFF} : q_q;
  assign quo_o  = neg_q ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
  assign done_o = done_q;

endmodule

>>> src/lcks_ctrl.sv
// Controller: steps through the micro-operation sequence for each request.
module lcks_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lcks_pkg::sts_t  sts_i,
  output lcks_pkg::cmd_t  cmd_o
);
  import lcks_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] pc_q, pc_d;
  op_e        op;
  kind_e      kind;

  assign op   = op_e'(pc_q);
  assign kind = op_kind(op);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cmd_o       = '0;
    cmd_o.op    = op;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = 5'(OP_CENTER);
          state_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (kind == KIND_LOCAL) begin
          // The last step waits for the output register to be free.
          if (!(op == OP_OUT && sts_i.out_full)) begin
            cmd_o.wb = 1'b1;
            if (op == OP_OUT) state_d = ST_IDLE;
            else pc_d = pc_q + 5'd1;
          end
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if ((kind == KIND_MUL && sts_i.mul_done) ||
            (kind == KIND_DIV && sts_i.div_done)) begin
          cmd_o.wb = 1'b1;
          pc_d     = pc_q + 5'd1;
          state_d  = ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

>>> src/lcks_dp.sv
// Datapath: configuration, filter and controller state, shared arithmetic units.
module lcks_dp #(
  parameter int STATE_FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  logic [1:0]      lines_found_i,
  input  logic [15:0]     first_x_i,
  input  logic [15:0]     second_x_i,
  input  lcks_pkg::cmd_t  cmd_i,
  output lcks_pkg::sts_t  sts_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [31:0]     steer_cmd_o,
  output logic [2:0]      speed_code_o,
  output logic [15:0]     raw_center_o,
  output logic [15:0]     filtered_center_o
);
  import lcks_pkg::*;

  localparam int NSH = 24 - STATE_FRAC_BITS;

  logic [11:0] w_q;
  logic [31:0] gp_q, gi_q, gd_q;
  logic [30:0] ts_q, pn_q, mn_q;

  s48_t pos_q, vel_q, p00_q, p01_q, p11_q, esum_q, last_q;
  s48_t xp_q, a_q, t00_q, p00n_q, p11n_q, y_q, s_q, k0_q, k1_q, e_q, d_q;
  logic signed [49:0] u_q;
  logic signed [17:0] center_q;
  logic signed [31:0] steer_q;
  logic [1:0]         n_q;
  logic signed [15:0] x1_q, x2_q;

  logic               outv_q;
  logic [31:0]        ostr_q;
  logic [2:0]         ospd_q;
  logic [15:0]        oraw_q, ofilt_q;

  s48_t dt, qn, rn, gp, gi, gd, wh, ma, mb, mres, e_c;
  logic [5:0]         msh;
  logic               mdone, ddone, dfrac;
  logic signed [49:0] dnum, x1w, w50, nc, nu;
  s48_t               nuc;
  logic [47:0]        dden;
  logic signed [50:0] quo;
  logic signed [16:0] lo, hi, sum2, half2, x1e, wh17;
  logic signed [17:0] center_c;
  logic [32:0]        as;
  logic [2:0]         spd;
  logic signed [15:0] raw_c, filt_c;
  s48_t               padj, fq;

  assign dt   = s48_t'({17'b0, ts_q});
  assign qn   = s48_t'({17'b0, pn_q} >> NSH);
  assign rn   = s48_t'({17'b0, mn_q} >> NSH);
  assign gp   = {{16{gp_q[31]}}, gp_q};
  assign gi   = {{16{gi_q[31]}}, gi_q};
  assign gd   = {{16{gd_q[31]}}, gd_q};
  assign wh   = s48_t'({36'b0, w_q}) <<< (STATE_FRAC_BITS - 1);
  assign e_c  = sat48(ext52(pos_q) - ext52(wh));

  // A sum too large for 48 bits saturates the steering result either way.
  assign nu  = -u_q;
  assign nuc = sat48({{2{nu[49]}}, nu});

  // Multiplier operand selection.
  always_comb begin
    ma  = '0;
    mb  = '0;
    msh = SH_DT;
    case (cmd_i.op)
      OP_CENTER: begin ma = nc[47:0]; mb = RCP_11; msh = SH_C11; end
      OP_XP:   begin ma = dt; mb = vel_q; end
      OP_A:    begin ma = dt; mb = p11_q; end
      OP_T00:  begin ma = dt; mb = p01_q; end
      OP_P00:  begin ma = dt; mb = a_q;   end
      OP_POS:  begin ma = k0_q; mb = y_q;    msh = SH_KG; end
      OP_VEL:  begin ma = k1_q; mb = y_q;    msh = SH_KG; end
      OP_UP00: begin ma = k0_q; mb = p00n_q; msh = SH_KG; end
      OP_UP01: begin ma = k0_q; mb = a_q;    msh = SH_KG; end
      OP_UP11: begin ma = k1_q; mb = a_q;    msh = SH_KG; end
      OP_UP:   begin ma = gp; mb = e_q;    msh = 6'(STATE_FRAC_BITS); end
      OP_UI:   begin ma = gi; mb = esum_q; msh = 6'(STATE_FRAC_BITS); end
      OP_UD:   begin ma = gd; mb = d_q;    msh = 6'(STATE_FRAC_BITS); end
      OP_STEER: begin ma = nuc; mb = RCP_3; msh = SH_C3; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Single-line centre: x shifted by 5W/11 towards the middle, via a reciprocal product.
  assign x1w = {{34{x1_q[15]}}, x1_q};
  assign w50 = {38'b0, w_q};
  assign x1e = {x1_q[15], x1_q};
  assign wh17 = {6'b0, w_q[11:1]};
  assign nc  = (x1e < wh17) ? (x1w <<< 3) + (x1w <<< 1) + x1w + (w50 <<< 2) + w50
                            : (x1w <<< 3) + (x1w <<< 1) + x1w - (w50 <<< 2) - w50;

  always_comb begin
    dfrac = 1'b0;
    dnum  = '0;
    dden  = 48'd3;
    case (cmd_i.op)
      OP_K0:     begin dnum = {{2{p00n_q[47]}}, p00n_q}; dden = s_q; dfrac = 1'b1; end
      OP_K1:     begin dnum = {{2{a_q[47]}}, a_q};       dden = s_q; dfrac = 1'b1; end
      default:   begin dnum = '0; dden = 48'd3; end
    endcase
  end

  lcks_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && op_kind(cmd_i.op) == KIND_MUL),
    .a_i     (ma),
    .b_i     (mb),
    .sh_i    (msh),
    .done_o  (mdone),
    .res_o   (mres)
  );

  lcks_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && op_kind(cmd_i.op) == KIND_DIV),
    .frac_i  (dfrac),
    .num_i   (dnum),
    .den_i   (dden),
    .done_o  (ddone),
    .quo_o   (quo)
  );

  // Two lines: midpoint truncated towards zero; none: mid-frame.
  assign lo    = (x1e < $signed({x2_q[15], x2_q})) ? x1e : $signed({x2_q[15], x2_q});
  assign hi    = (x1e < $signed({x2_q[15], x2_q})) ? $signed({x2_q[15], x2_q}) : x1e;
  assign sum2  = lo + hi;
  assign half2 = (sum2 + $signed({16'b0, sum2[16]})) >>> 1;
  always_comb begin
    case (n_q)
      2'd0:    center_c = {7'b0, w_q[11:1]};
      2'd1:    center_c = mres[17:0];
      default: center_c = {half2[16], half2};
    endcase
  end

  // Result formatting.
  assign as = steer_q[31] ? 33'(-{steer_q[31], steer_q}) : {1'b0, steer_q};
  always_comb begin
    if (as <= LIM_DEG5) spd = SPD_1P5;
    else if (as <= LIM_DEG8) spd = SPD_1P2;
    else if (as <= LIM_DEG11P5) spd = SPD_1P0;
    else if (as <= LIM_DEG15) spd = SPD_0P8;
    else spd = SPD_0P7;
    if (center_q > 18'sd32767) raw_c = 16'sh7FFF;
    else if (center_q < -18'sd32768) raw_c = 16'sh8000;
    else raw_c = center_q[15:0];
    padj = pos_q[47] ? pos_q + ((s48_t'(1) <<< STATE_FRAC_BITS) - s48_t'(1)) : pos_q;
    fq   = padj >>> STATE_FRAC_BITS;
    if (fq > 48'sd32767) filt_c = 16'sh7FFF;
    else if (fq < -48'sd32768) filt_c = 16'sh8000;
    else filt_c = fq[15:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q  <= RST_WIDTH;
      gp_q <= RST_GAIN_P;
      gi_q <= RST_GAIN_I;
      gd_q <= RST_GAIN_D;
      ts_q <= RST_DT;
      pn_q <= RST_QNOISE;
      mn_q <= RST_RNOISE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:  w_q  <= cfg_data_i[11:0];
        CFG_GAIN_P: gp_q <= cfg_data_i;
        CFG_GAIN_I: gi_q <= cfg_data_i;
        CFG_GAIN_D: gd_q <= cfg_data_i;
        CFG_DT:     ts_q <= cfg_data_i[30:0];
        CFG_QNOISE: pn_q <= cfg_data_i[30:0];
        CFG_RNOISE: mn_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // Filter and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      p00_q  <= s48_t'(1) <<< STATE_FRAC_BITS;
      p01_q  <= '0;
      p11_q  <= s48_t'(1) <<< STATE_FRAC_BITS;
      esum_q <= '0;
      last_q <= '0;
    end else if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_POS:  pos_q <= sat48(ext52(xp_q) + ext52(mres));
        OP_VEL:  vel_q <= sat48(ext52(vel_q) + ext52(mres));
        OP_UP00: p00_q <= sat48(ext52(p00n_q) - ext52(mres));
        OP_UP01: p01_q <= sat48(ext52(a_q) - ext52(mres));
        OP_UP11: p11_q <= sat48(ext52(p11n_q) - ext52(mres));
        OP_PID: begin
          esum_q <= sat48(ext52(esum_q) + ext52(e_c));
          last_q <= e_c;
        end
        default: ;
      endcase
    end
  end

  // Working values of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q  <= lines_found_i;
      x1_q <= first_x_i;
      x2_q <= second_x_i;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_CENTER: center_q <= center_c;
        OP_XP:     xp_q  <= sat48(ext52(pos_q) + ext52(mres));
        OP_A:      a_q   <= sat48(ext52(p01_q) + ext52(mres));
        OP_T00:    t00_q <= sat48(ext52(p00_q) + ext52(mres));
        OP_P00:    p00n_q <= sat48(ext52(t00_q) + ext52(mres) + ext52(qn));
        OP_PREP: begin
          p11n_q <= sat48(ext52(p11_q) + ext52(qn));
          y_q    <= sat48((s52_t'(center_q) <<< STATE_FRAC_BITS) - ext52(xp_q));
          s_q    <= sat48(ext52(p00n_q) + ext52(rn));
        end
        OP_K0:  k0_q <= (!s_q[47] && s_q != '0) ? quo[47:0] : '0;
        OP_K1:  k1_q <= (!s_q[47] && s_q != '0) ? quo[47:0] : '0;
        OP_PID: begin
          e_q <= e_c;
          d_q <= sat48(ext52(e_c) - ext52(last_q));
        end
        OP_UP: u_q <= {{2{mres[47]}}, mres};
        OP_UI: u_q <= u_q + {{2{mres[47]}}, mres};
        OP_UD: u_q <= u_q + {{2{mres[47]}}, mres};
        OP_STEER: begin
          if (mres > 48'sd2147483647) steer_q <= 32'sh7FFF_FFFF;
          else if (mres < -48'sd2147483648) steer_q <= 32'sh8000_0000;
          else steer_q <= mres[31:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.wb && cmd_i.op == OP_OUT) begin
      ostr_q  <= steer_q;
      ospd_q  <= spd;
      oraw_q  <= raw_c;
      ofilt_q <= filt_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outv_q <= 1'b0;
    end else if (cmd_i.wb && cmd_i.op == OP_OUT) begin
      outv_q <= 1'b1;
    end else if (out_ready_i) begin
      outv_q <= 1'b0;
    end
  end

  assign sts_o.mul_done  = mdone;
  assign sts_o.div_done  = ddone;
  assign sts_o.out_full  = outv_q;
  assign out_valid_o       = outv_q;
  assign steer_cmd_o       = ostr_q;
  assign speed_code_o      = ospd_q;
  assign raw_center_o      = oraw_q;
  assign filtered_center_o = ofilt_q;

endmodule
